[hw/rtl/multi_pipe_fifo_manager_macros.svh]
// assertion macros used by the fifo manager rtl
`ifndef MULTI_PIPE_FIFO_MANAGER_MACROS_SVH
`define MULTI_PIPE_FIFO_MANAGER_MACROS_SVH

// implication checked on every rising edge outside reset
`define MPF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication with the consequent checked in the cycle after the antecedent
`define MPF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/mpf_pkg.sv]
package mpf_pkg;
    localparam int DefNumSlots  = 16;
    localparam int DefRingDepth = 1024;
    localparam int IdentW       = 16;
    localparam int ByteW        = 8;
    localparam int OpW          = 3;
    localparam int StatW        = 3;
    localparam int OccW         = 11;
    localparam logic [IdentW-1:0] AutoIdReset = 16'd10;
    localparam logic [IdentW-1:0] IdentMax    = 16'hFFFF;

    typedef enum logic [OpW-1:0] {
        OP_CREATE = 3'd0,
        OP_AUTO   = 3'd1,
        OP_DESTROY= 3'd2,
        OP_EOF    = 3'd3,
        OP_WRITE  = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [StatW-1:0] {
        ST_OK      = 3'd0,
        ST_BADID   = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_BLOCK   = 3'd3,
        ST_EOF     = 3'd4
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_META,
        S_SEARCH,
        S_BYTE,
        S_OUT
    } fsm_t;
endpackage

[hw/rtl/mpf_ram.sv]
module mpf_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
    assign rdata = rdata_reg;
endmodule

[hw/rtl/mpf_ident_table.sv]
module mpf_ident_table
    import mpf_pkg::*;
#(
    parameter int NumSlots = DefNumSlots
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [IdentW-1:0]           look_ident,
    output logic                        hit,
    output logic [$clog2(NumSlots+1)-1:0] hit_slot,
    output logic                        free_ok,
    output logic [$clog2(NumSlots+1)-1:0] free_slot,
    input  logic                        set_en,
    input  logic [$clog2(NumSlots+1)-1:0] set_slot,
    input  logic [IdentW-1:0]           set_ident
);
    localparam int SW  = $clog2(NumSlots + 1);
    localparam int SAW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
    logic [IdentW-1:0] ident_reg [NumSlots];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumSlots; i++) ident_reg[i] <= '0;
        end else if (set_en) begin
            ident_reg[set_slot[SAW-1:0]] <= set_ident;
        end
    end

    // parallel compare, lowest index wins
    always_comb begin
        hit = 1'b0;
        hit_slot = '0;
        free_ok = 1'b0;
        free_slot = '0;
        for (int i = NumSlots - 1; i >= 0; i--) begin
            if (look_ident != '0 && ident_reg[i] == look_ident) begin
                hit = 1'b1;
                hit_slot = SW'(i);
            end
            if (ident_reg[i] == '0) begin
                free_ok = 1'b1;
                free_slot = SW'(i);
            end
        end
    end
endmodule

[hw/rtl/multi_pipe_fifo_manager.sv]
// Multi-pipe byte fifo manager. Up to NUM_SLOTS byte pipes, each named by a
// nonzero 16-bit id, share one byte memory of NUM_SLOTS*RING_DEPTH entries;
// per-pipe ring pointers, fill count and eof mark live in a second memory
// read, modified and written back per item. One item is handled at a time:
// after the accepting edge, create, a failed lookup or an unknown opcode go
// from S_META to S_OUT; destroy, eof, write and read pass S_META, S_BYTE (the
// pointer memory read) and S_OUT, where the byte memory read result arrives.
// An automatic create probes one candidate id per cycle in S_SEARCH from
// first_auto_id, at most NUM_SLOTS probes. A new item is taken the cycle after
// the result is accepted. Configuration is written through cfg_wr_en/data.
module multi_pipe_fifo_manager
    import mpf_pkg::*;
#(
    parameter int NUM_SLOTS  = DefNumSlots,
    parameter int RING_DEPTH = DefRingDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // first_auto_id
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // opcode[2:0], pipe_ident[18:3], write_byte[26:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // status[2:0], result_ident[18:3],
                                       // read_byte[26:19], occupancy[37:27]
);
    `include "multi_pipe_fifo_manager_macros.svh"

    localparam int SW  = $clog2(NUM_SLOTS + 1);
    localparam int SAW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int MW  = 2 * RW + CW + 1;
    localparam int BD  = NUM_SLOTS * RING_DEPTH;
    localparam int BAW = $clog2(BD);

    fsm_t state_reg, state_next;
    logic [IdentW-1:0] auto_id_reg;
    logic [OpW-1:0]    op_reg;
    logic [IdentW-1:0] id_reg, id_next;
    logic [ByteW-1:0]  wb_reg;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [StatW-1:0]  st_reg, st_next;
    logic [IdentW-1:0] rid_reg, rid_next;
    logic [ByteW-1:0]  rb_reg, rb_next;
    logic [OccW-1:0]   occ_reg, occ_next;
    logic              rd_byte_reg, rd_byte_next;

    // identifier table
    logic [IdentW-1:0] look_ident;
    logic hit, free_ok, set_en;
    logic [SW-1:0] hit_slot, free_slot, set_slot;
    logic [IdentW-1:0] set_ident;

    mpf_ident_table #(.NumSlots(NUM_SLOTS)) u_tab (
        .aclk, .aresetn, .look_ident, .hit, .hit_slot, .free_ok, .free_slot,
        .set_en, .set_slot, .set_ident
    );

    // pointer memory: {eof, fill, rd, wr}; reset via per-slot valid bits
    logic [NUM_SLOTS-1:0] mvalid_reg;
    logic meta_we;
    logic [SAW-1:0] meta_waddr, meta_raddr;
    logic [MW-1:0] meta_wdata, meta_rraw, meta_q;
    mpf_ram #(.Width(MW), .Depth(NUM_SLOTS)) u_meta (
        .aclk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .raddr(meta_raddr), .rdata(meta_rraw)
    );
    assign meta_q = mvalid_reg[slot_reg[SAW-1:0]] ? meta_rraw : '0;
    logic [RW-1:0] m_wr, m_rd;
    logic [CW-1:0] m_fill;
    logic          m_eof;
    assign {m_eof, m_fill, m_rd, m_wr} = meta_q;

    // byte memory
    logic byte_we;
    logic [BAW-1:0] byte_waddr, byte_raddr;
    logic [ByteW-1:0] byte_q;
    mpf_ram #(.Width(ByteW), .Depth(BD)) u_bytes (
        .aclk, .we(byte_we), .waddr(byte_waddr), .wdata(wb_reg),
        .raddr(byte_raddr), .rdata(byte_q)
    );

    function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] x);
        return (32'(x) >= RING_DEPTH - 1) ? '0 : x + RW'(1);
    endfunction

    logic [BAW-1:0] slot_base;
    assign slot_base = BAW'(slot_reg[SAW-1:0]) * BAW'(RING_DEPTH);

    // read byte lands in the cycle after S_BYTE; pick it up for the output word
    logic [ByteW-1:0] out_rb;
    assign out_rb = rd_byte_reg ? byte_q : rb_reg;

    logic in_acc;
    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !m_tvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            auto_id_reg <= AutoIdReset;
            m_tvalid    <= 1'b0;
            mvalid_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) auto_id_reg <= cfg_wr_data;
            if (state_reg == S_OUT) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
            if (meta_we) mvalid_reg[meta_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            op_reg <= s_tdata[2:0];
            wb_reg <= s_tdata[26:19];
        end
        id_reg      <= in_acc ? s_tdata[18:3] : id_next;
        slot_reg    <= slot_next;
        st_reg      <= st_next;
        rid_reg     <= rid_next;
        rb_reg      <= rb_next;
        occ_reg     <= occ_next;
        rd_byte_reg <= rd_byte_next;
        if (state_reg == S_OUT) m_tdata <= {2'b0, occ_reg, out_rb, rid_reg, st_reg};
    end

    always_comb begin
        state_next = state_reg;
        id_next = id_reg;
        slot_next = slot_reg;
        st_next = st_reg;
        rid_next = rid_reg;
        rb_next = rb_reg;
        occ_next = occ_reg;
        rd_byte_next = rd_byte_reg;
        look_ident = id_reg;
        set_en = 1'b0;
        set_slot = slot_reg;
        set_ident = id_reg;
        meta_we = 1'b0;
        meta_waddr = slot_reg[SAW-1:0];
        meta_wdata = '0;
        meta_raddr = slot_reg[SAW-1:0];
        byte_we = 1'b0;
        byte_waddr = slot_base + BAW'(m_wr);
        byte_raddr = slot_base + BAW'(m_rd);
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_META;
                end
            end
            S_META: begin
                // decide using parallel compare; launch pointer read
                rb_next = '0;
                occ_next = '0;
                rid_next = id_reg;
                rd_byte_next = 1'b0;
                state_next = S_OUT;
                case (op_reg) inside
                    OP_CREATE: begin
                        if (id_reg == '0) st_next = ST_BADID;
                        else if (!free_ok) st_next = ST_NOSPACE;
                        else if (hit) st_next = ST_BADID;
                        else begin
                            st_next = ST_OK;
                            set_en = 1'b1;
                            set_slot = free_slot;
                            meta_we = 1'b1;
                            meta_waddr = free_slot[SAW-1:0];
                        end
                    end
                    OP_AUTO: begin
                        rid_next = '0;
                        st_next = ST_NOSPACE;
                        if (free_ok) begin
                            id_next = (auto_id_reg == '0) ? IdentW'(1) : auto_id_reg;
                            slot_next = free_slot;
                            state_next = S_SEARCH;
                        end
                    end
                    OP_DESTROY, OP_EOF, OP_WRITE, OP_READ: begin
                        if (!hit) st_next = ST_BADID;
                        else begin
                            slot_next = hit_slot;
                            meta_raddr = hit_slot[SAW-1:0];
                            state_next = S_BYTE;
                        end
                    end
                    default: begin
                        st_next = ST_BADID;
                        rid_next = '0;
                    end
                endcase
            end
            S_SEARCH: begin
                // one candidate id per cycle
                if (!hit) begin
                    st_next = ST_OK;
                    rid_next = id_reg;
                    set_en = 1'b1;
                    meta_we = 1'b1;
                    state_next = S_OUT;
                end else if (id_reg == IdentMax) begin
                    state_next = S_OUT;
                end else begin
                    id_next = id_reg + IdentW'(1);
                end
            end
            S_BYTE: begin
                // pointer data ready: modify, write back, touch byte memory
                st_next = ST_OK;
                occ_next = OccW'(m_fill);
                meta_we = 1'b1;
                meta_wdata = meta_q;
                state_next = S_OUT;
                case (op_reg)
                    OP_DESTROY: begin
                        set_en = 1'b1;
                        set_ident = '0;
                        meta_wdata = '0;
                        occ_next = '0;
                    end
                    OP_EOF: begin
                        meta_wdata = {1'b1, m_fill, m_rd, m_wr};
                    end
                    OP_WRITE: begin
                        if (32'(m_fill) >= RING_DEPTH) st_next = ST_BLOCK;
                        else begin
                            byte_we = 1'b1;
                            meta_wdata = {m_eof, m_fill + CW'(1), m_rd, ring_next(m_wr)};
                            occ_next = OccW'(m_fill + CW'(1));
                        end
                    end
                    default: begin
                        if (m_fill == '0) st_next = m_eof ? ST_EOF : ST_BLOCK;
                        else begin
                            rd_byte_next = 1'b1;
                            meta_wdata = {m_eof, m_fill - CW'(1), ring_next(m_rd), m_wr};
                            occ_next = OccW'(m_fill - CW'(1));
                        end
                    end
                endcase
            end
            S_OUT: begin
                state_next = S_IDLE;
                if (rd_byte_reg) rb_next = byte_q;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `MPF_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_tready)
    `MPF_ASSERT_NEXT(a_out_follows, aclk, aresetn, state_reg == S_OUT, m_tvalid)
    `MPF_ASSERT_IMP(a_rb_only_ok, aclk, aresetn, rd_byte_reg && state_reg == S_OUT,
        st_reg == ST_OK && out_rb == byte_q)
endmodule
